// ----- sv/pidsv_pkg.sv -----
// Package for the PID step block: widths, reset values, register codes,
// sequencer states, operation codes and the control and configuration structs.
// No dependencies.
package pidsv_pkg;

   localparam int unsigned ErrWidth     = 16;
   localparam int unsigned StepWidth    = 16;
   localparam int unsigned GainWidth    = 16;
   localparam int unsigned LimitWidth   = 31;
   localparam int unsigned IntegWidth   = 32;
   localparam int unsigned OutWidth     = 32;
   localparam int unsigned ProdWidth    = 49;
   localparam int unsigned SumWidth     = 48;
   localparam int unsigned DivBits      = 44;
   localparam int unsigned DivCntWidth  = $clog2(DivBits);
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [StepWidth-1:0]  ZeroStepUnits   = 16'd66;
   localparam logic [GainWidth-1:0]  PropGainReset   = 16'd256;
   localparam logic [GainWidth-1:0]  IntegGainReset  = 16'd0;
   localparam logic [GainWidth-1:0]  DerivGainReset  = 16'd0;
   localparam logic [LimitWidth-1:0] IntegLimitReset = 31'd65536;

   typedef enum logic [1:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_DERIV_GAIN,
      REG_INTEG_LIMIT
   } pidsv_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_INC,
      ST_CLAMP,
      ST_MUL_PROP,
      ST_ADD_PROP,
      ST_MUL_INTEG,
      ST_ADD_INTEG,
      ST_MUL_DERIV,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } pidsv_state_type;

   typedef enum logic [1:0] {
      MUL_INC,
      MUL_PROP,
      MUL_INTEG,
      MUL_DERIV
   } pidsv_mul_op_type;

   typedef enum logic {
      ACC_LOAD_PROP,
      ACC_ADD_INTEG
   } pidsv_acc_op_type;

   typedef struct packed {
      logic [GainWidth-1:0]  prop_gain;
      logic [GainWidth-1:0]  integ_gain;
      logic [GainWidth-1:0]  deriv_gain;
      logic [LimitWidth-1:0] integ_limit;
   } pidsv_cfg_type;

   typedef struct packed {
      logic             load_in;
      logic             mul_en;
      pidsv_mul_op_type mul_op;
      logic             clamp_en;
      logic             acc_en;
      pidsv_acc_op_type acc_op;
      logic             div_load;
      logic             div_step;
      logic             result_en;
   } pidsv_ctrl_type;

endpackage

// ----- sv/pid_step_variable_dt_core.sv -----
// Top level of the PID step block with variable time step and integral clamp.
// Depends on pidsv_pkg, pidsv_csr, pidsv_ctrl and pidsv_dpath.
//
// Usage: a request on the req_ stream carries an error sample and the time
// since the previous request. The block updates the clamped integral, forms
// P + I + D and returns one response on the rsp_ stream with the saturated
// drive value in tdata and the saturation flag in tuser. Gains and the
// integral limit are set through the csr_ port; the user is bound to do so
// only while no request is in work, as the block does not enforce it.
// After a request is accepted, eight sequencer steps run, four of them on
// one shared multiplier; then the bit-serial divider for the derivative term
// forms one quotient bit per cycle, and last the output register is loaded.
// req_tready is high only while the sequencer is idle, so a new request is
// accepted only once the sequencer has finished with the last one.
// The response sits in an output register; the next request is accepted while
// it waits, and a finished result holds in the sequencer until the register
// is free. Reset clears the integral, the stored error, the handshakes and
// returns the gains and limit to their defaults.
module pid_step_variable_dt_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] error_sample, [31:16] time_step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] control_out
   output logic [0:0]  rsp_tuser,   // [0] out_saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pidsv_pkg::pidsv_cfg_type  cfg;
   pidsv_pkg::pidsv_ctrl_type ctrl;
   logic signed [31:0]        control_out;
   logic                      out_saturated;

   pidsv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidsv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   pidsv_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg),
      .in_error_sample ($signed(req_tdata[15:0])),
      .in_time_step    (req_tdata[31:16]),
      .control_out     (control_out),
      .out_saturated   (out_saturated)
   );

   assign rsp_tdata    = control_out;
   assign rsp_tuser[0] = out_saturated;

endmodule

// ----- sv/pidsv_csr.sv -----
// Configuration register file of the PID step block on an APB-style port.
// Depends on pidsv_pkg.
module pidsv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pidsv_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [pidsv_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [pidsv_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                csr_pready,
   output pidsv_pkg::pidsv_cfg_type            cfg
);

   pidsv_pkg::pidsv_cfg_type cfg_ff, cfg_in;
   pidsv_pkg::pidsv_reg_type reg_sel;
   logic                     wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = pidsv_pkg::pidsv_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            pidsv_pkg::REG_PROP_GAIN:   cfg_in.prop_gain   = csr_pwdata[15:0];
            pidsv_pkg::REG_INTEG_GAIN:  cfg_in.integ_gain  = csr_pwdata[15:0];
            pidsv_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain  = csr_pwdata[15:0];
            pidsv_pkg::REG_INTEG_LIMIT: cfg_in.integ_limit = csr_pwdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pidsv_pkg::REG_PROP_GAIN:   csr_prdata = {16'd0, cfg_ff.prop_gain};
         pidsv_pkg::REG_INTEG_GAIN:  csr_prdata = {16'd0, cfg_ff.integ_gain};
         pidsv_pkg::REG_DERIV_GAIN:  csr_prdata = {16'd0, cfg_ff.deriv_gain};
         pidsv_pkg::REG_INTEG_LIMIT: csr_prdata = {1'b0, cfg_ff.integ_limit};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= pidsv_pkg::PropGainReset;
         cfg_ff.integ_gain  <= pidsv_pkg::IntegGainReset;
         cfg_ff.deriv_gain  <= pidsv_pkg::DerivGainReset;
         cfg_ff.integ_limit <= pidsv_pkg::IntegLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/pidsv_ctrl.sv -----
// Sequencer of the PID step block: steps the shared multiplier, the clamp,
// the accumulator and the divider, and owns the handshakes. Depends on pidsv_pkg.
module pidsv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output pidsv_pkg::pidsv_ctrl_type ctrl
);

   pidsv_pkg::pidsv_state_type           state_ff, state_in;
   logic [pidsv_pkg::DivCntWidth-1:0]    div_cnt_ff, div_cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 slot_free;
   logic                                 div_last;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign div_last   = (div_cnt_ff == pidsv_pkg::DivCntWidth'(pidsv_pkg::DivBits - 1));
   assign req_tready = (state_ff == pidsv_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidsv_pkg::ST_IDLE:      if (req_tvalid) state_in = pidsv_pkg::ST_MUL_INC;
         pidsv_pkg::ST_MUL_INC:   state_in = pidsv_pkg::ST_CLAMP;
         pidsv_pkg::ST_CLAMP:     state_in = pidsv_pkg::ST_MUL_PROP;
         pidsv_pkg::ST_MUL_PROP:  state_in = pidsv_pkg::ST_ADD_PROP;
         pidsv_pkg::ST_ADD_PROP:  state_in = pidsv_pkg::ST_MUL_INTEG;
         pidsv_pkg::ST_MUL_INTEG: state_in = pidsv_pkg::ST_ADD_INTEG;
         pidsv_pkg::ST_ADD_INTEG: state_in = pidsv_pkg::ST_MUL_DERIV;
         pidsv_pkg::ST_MUL_DERIV: state_in = pidsv_pkg::ST_DIV_LOAD;
         pidsv_pkg::ST_DIV_LOAD:  state_in = pidsv_pkg::ST_DIV;
         pidsv_pkg::ST_DIV:       if (div_last) state_in = pidsv_pkg::ST_FINISH;
         pidsv_pkg::ST_FINISH:    if (slot_free) state_in = pidsv_pkg::ST_IDLE;
         default:                 state_in = pidsv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl        = '0;
      ctrl.mul_op = pidsv_pkg::MUL_INC;
      ctrl.acc_op = pidsv_pkg::ACC_LOAD_PROP;
      case (state_ff)
         pidsv_pkg::ST_IDLE:      ctrl.load_in = req_tvalid;
         pidsv_pkg::ST_MUL_INC: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = pidsv_pkg::MUL_INC;
         end
         pidsv_pkg::ST_CLAMP:     ctrl.clamp_en = 1'b1;
         pidsv_pkg::ST_MUL_PROP: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = pidsv_pkg::MUL_PROP;
         end
         pidsv_pkg::ST_ADD_PROP: begin
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = pidsv_pkg::ACC_LOAD_PROP;
         end
         pidsv_pkg::ST_MUL_INTEG: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = pidsv_pkg::MUL_INTEG;
         end
         pidsv_pkg::ST_ADD_INTEG: begin
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = pidsv_pkg::ACC_ADD_INTEG;
         end
         pidsv_pkg::ST_MUL_DERIV: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = pidsv_pkg::MUL_DERIV;
         end
         pidsv_pkg::ST_DIV_LOAD:  ctrl.div_load = 1'b1;
         pidsv_pkg::ST_DIV:       ctrl.div_step = 1'b1;
         pidsv_pkg::ST_FINISH:    ctrl.result_en = slot_free;
         default:                 ctrl.load_in = 1'b0;
      endcase
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (ctrl.div_load) begin
         div_cnt_in = '0;
      end else if (ctrl.div_step) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.result_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidsv_pkg::ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/pidsv_dpath.sv -----
// Datapath of the PID step block: shared multiplier, integral clamp, term
// accumulator, bit-serial divider and output register. Depends on pidsv_pkg.
module pidsv_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pidsv_pkg::pidsv_ctrl_type               ctrl,
   input  pidsv_pkg::pidsv_cfg_type                cfg,
   input  logic signed [pidsv_pkg::ErrWidth-1:0]   in_error_sample,
   input  logic [pidsv_pkg::StepWidth-1:0]         in_time_step,
   output logic signed [pidsv_pkg::OutWidth-1:0]   control_out,
   output logic                                    out_saturated
);

   logic signed [15:0] err_ff, prev_err_ff, prev_err_in;
   logic [15:0]        step_ff;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [48:0] prod_ff;
   logic signed [47:0] sum_ff;
   logic [43:0]        div_num_ff;
   logic [15:0]        div_rem_ff;
   logic               div_neg_ff;
   logic signed [31:0] out_ff;
   logic               out_sat_ff;

   logic signed [31:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [48:0] mul_p;
   logic signed [16:0] err_diff;
   logic signed [48:0] prod_shr12, prod_shr8, prod_shr4;
   logic signed [32:0] integ_sum, lim_pos, lim_neg;
   logic signed [47:0] addend, acc_base;
   logic signed [48:0] prod_mag;
   logic [16:0]        rem_shift;
   logic               q_bit;
   logic signed [44:0] q_mag, d_term;
   logic signed [47:0] total;
   logic               fits;

   assign err_diff = {err_ff[15], err_ff} - {prev_err_ff[15], prev_err_ff};

   always_comb begin
      case (ctrl.mul_op)
         pidsv_pkg::MUL_INC: begin
            mul_a = {{16{err_ff[15]}}, err_ff};
            mul_b = {1'b0, step_ff};
         end
         pidsv_pkg::MUL_PROP: begin
            mul_a = {{16{err_ff[15]}}, err_ff};
            mul_b = {1'b0, cfg.prop_gain};
         end
         pidsv_pkg::MUL_INTEG: begin
            mul_a = integ_ff;
            mul_b = {1'b0, cfg.integ_gain};
         end
         pidsv_pkg::MUL_DERIV: begin
            mul_a = {{15{err_diff[16]}}, err_diff};
            mul_b = {1'b0, cfg.deriv_gain};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      prod_shr12 = prod_ff >>> 12;
      integ_sum  = {integ_ff[31], integ_ff} + $signed(prod_shr12[32:0]);
      lim_pos    = $signed({2'b00, cfg.integ_limit});
      lim_neg    = -lim_pos;
      integ_in   = integ_ff;
      if (integ_sum > lim_pos) begin
         integ_in = lim_pos[31:0];
      end else if (integ_sum < lim_neg) begin
         integ_in = lim_neg[31:0];
      end else begin
         integ_in = integ_sum[31:0];
      end
   end

   always_comb begin
      prod_shr8 = prod_ff >>> 8;
      prod_shr4 = prod_ff >>> 4;
      if (ctrl.acc_op == pidsv_pkg::ACC_LOAD_PROP) begin
         addend   = $signed(prod_shr4[47:0]);
         acc_base = '0;
      end else begin
         addend   = $signed(prod_shr8[47:0]);
         acc_base = sum_ff;
      end
   end

   always_comb begin
      prod_mag  = prod_ff[48] ? -prod_ff : prod_ff;
      rem_shift = {div_rem_ff, div_num_ff[43]};
      q_bit     = (rem_shift >= {1'b0, step_ff});
      q_mag     = $signed({1'b0, div_num_ff});
      d_term    = div_neg_ff ? -q_mag : q_mag;
      total     = sum_ff + {{3{d_term[44]}}, d_term};
      fits      = (total[47:31] == '0) || (total[47:31] == '1);
      prev_err_in = ctrl.result_en ? err_ff : prev_err_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_in) begin
         err_ff  <= in_error_sample;
         step_ff <= (in_time_step == '0) ? pidsv_pkg::ZeroStepUnits : in_time_step;
      end
      if (ctrl.mul_en) begin
         prod_ff <= mul_p;
      end
      if (ctrl.acc_en) begin
         sum_ff <= acc_base + addend;
      end
      if (ctrl.div_load) begin
         div_num_ff <= {prod_mag[31:0], 12'd0};
         div_rem_ff <= '0;
         div_neg_ff <= prod_ff[48];
      end else if (ctrl.div_step) begin
         div_num_ff <= {div_num_ff[42:0], q_bit};
         div_rem_ff <= q_bit ? 16'(rem_shift - {1'b0, step_ff}) : rem_shift[15:0];
      end
      if (ctrl.result_en) begin
         out_sat_ff <= !fits;
         if (fits) begin
            out_ff <= total[31:0];
         end else if (total[47]) begin
            out_ff <= 32'sh8000_0000;
         end else begin
            out_ff <= 32'sh7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else begin
         if (ctrl.clamp_en) begin
            integ_ff <= integ_in;
         end
         prev_err_ff <= prev_err_in;
      end
   end

   assign control_out   = out_ff;
   assign out_saturated = out_sat_ff;

endmodule

// ----- sv/pidsv_checker.sv -----
// Port-level checks for the PID step block, bound to its top level.
// Depends on pid_step_variable_dt_core.
module pidsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Request accepted while another is in work.");

   // No response can follow its request in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("Response appeared too early.");

   // A saturated result sits exactly on one of the two bounds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("Saturation flag without a bound value.");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("Stalled response changed.");

endmodule

bind pid_step_variable_dt_core pidsv_checker u_pidsv_checker (.*);

// ----- verif/pid_step_variable_dt_core_test.sv -----
// Self-checking test of pid_step_variable_dt_core: requests on the req_ stream, gains over csr_,
// drive values on rsp_ compared against a cycle-free model of the clamped PID step.
// Depends on pidsv_pkg and the block's RTL only.
module pid_step_variable_dt_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint DriveMax   = 64'sd2147483647;
   localparam longint DriveMin   = -64'sd2147483648;
   localparam int     StallLimit = 5000;

   typedef struct {
      logic [31:0] control_out;
      logic        out_saturated;
   } drive_result_type;

   class pid_drive_checker;
      longint prop_gain   = 256;
      longint integ_gain  = 0;
      longint deriv_gain  = 0;
      longint integ_limit = 65536;
      longint integral_acc = 0;
      longint last_error   = 0;
      drive_result_type pending_drives[$];
      int errors = 0;

      function void write_reg(pidsv_pkg::pidsv_reg_type r, logic [31:0] v);
         case (r)
            pidsv_pkg::REG_PROP_GAIN:   prop_gain   = v[15:0];
            pidsv_pkg::REG_INTEG_GAIN:  integ_gain  = v[15:0];
            pidsv_pkg::REG_DERIV_GAIN:  deriv_gain  = v[15:0];
            pidsv_pkg::REG_INTEG_LIMIT: integ_limit = v[30:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [15:0] err_bits, logic [15:0] step);
         longint e, t, acc, p, ig, d, total;
         drive_result_type r;
         e = longint'($signed(err_bits));
         t = (step == 16'd0) ? longint'(pidsv_pkg::ZeroStepUnits) : longint'(step);
         acc = integral_acc + ((e * t) >>> 12);
         if (acc > integ_limit) acc = integ_limit;
         if (acc < -integ_limit) acc = -integ_limit;
         integral_acc = acc;
         p = (prop_gain * e) >>> 4;
         ig = (integ_gain * acc) >>> 8;
         d = (deriv_gain * (e - last_error) * 64'sd4096) / t;
         total = p + ig + d;
         r.out_saturated = 1'b1;
         if (total > DriveMax) total = DriveMax;
         else if (total < DriveMin) total = DriveMin;
         else r.out_saturated = 1'b0;
         r.control_out = total[31:0];
         last_error = e;
         pending_drives.push_back(r);
      endfunction

      function void check_drive(logic [31:0] control, logic saturated);
         drive_result_type r;
         if (pending_drives.size() == 0) begin
            $error("Response with no request outstanding: control_out %0d", $signed(control));
            errors++;
            return;
         end
         r = pending_drives.pop_front();
         if (control !== r.control_out) begin
            $error("control_out mismatch: expected %0d, actual %0d",
                   $signed(r.control_out), $signed(control));
            errors++;
         end
         if (saturated !== r.out_saturated) begin
            $error("out_saturated mismatch: expected %0b, actual %0b",
                   r.out_saturated, saturated);
            errors++;
         end
      endfunction

      function int pending();
         return pending_drives.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] error_sample, [31:16] time_step
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] control_out
   logic [0:0]  rsp_tuser;        // [0] out_saturated
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pid_drive_checker drives = new();
   bit steady = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   pid_step_variable_dt_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Responses are taken with random short stalls and, now and then, a long one
   // that holds a finished result inside the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) drives.check_drive(rsp_tdata, rsp_tuser[0]);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 299) == 0) begin
            stall_left = $urandom_range(40, 160);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 32);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(input logic [15:0] err, input logic [15:0] step);
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {step, err};
      do @(posedge clock); while (!req_tready);
      drives.note_request(err, step);
   endtask

   task automatic write_csr(input pidsv_pkg::pidsv_reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      drives.write_reg(r, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (drives.pending() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] p, input logic [31:0] i,
                                 input logic [31:0] d, input logic [31:0] l);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_drained();
      write_csr(pidsv_pkg::REG_PROP_GAIN, p);
      write_csr(pidsv_pkg::REG_INTEG_GAIN, i);
      write_csr(pidsv_pkg::REG_DERIV_GAIN, d);
      write_csr(pidsv_pkg::REG_INTEG_LIMIT, l);
   endtask

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h0000_FFFF;
         2: return $urandom_range(0, 512);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_limit();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 4096);
         3: return $urandom_range(0, 1 << 22);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] random_error();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'($signed($urandom_range(0, 512)) - 256);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] random_step();
      case ($urandom_range(0, 19))
         0, 1: return 16'd0;
         2: return 16'd1;
         3: return 16'hFFFF;
         4, 5, 6, 7, 8, 9: return 16'($urandom_range(1, 200));
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset gains: pure proportional response.
      send_request(16'h7FFF, 16'd0);
      send_request(16'h8000, 16'hFFFF);
      send_request(16'h0000, 16'd1);
      send_request(16'd1234, 16'd66);

      // All registers at their maximum, with the unused upper bits set.
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(16'h7FFF, 16'd1);
      send_request(16'h8000, 16'd1);
      send_request(16'h0000, 16'd0);
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h8000, 16'd0);
      send_request(16'hFFFF, 16'hFFFF);

      // A zero limit pins the integral at zero.
      apply_settings(32'h80, 32'h100, 32'h0, 32'h0);
      send_request(16'd12345, 16'd100);
      send_request(-16'sd12345, 16'd0);

      // Drive the integral into the clamp on both sides.
      apply_settings(32'h100, 32'h1000, 32'h40, 32'd20000);
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h8000, 16'hFFFF);
      send_request(16'h8000, 16'hFFFF);
      send_request(16'h0000, 16'd0);

      apply_settings(32'h0, 32'h0, 32'h0, 32'h0);
      send_request(16'h7FFF, 16'd1);

      for (int ph = 0; ph < 8; ph++) begin
         apply_settings(random_gain(), random_gain(), random_gain(), random_limit());
         steady = (ph == 3);
         repeat (200) send_request(random_error(), random_step());
         steady = 1'b0;
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (60) @(posedge clock);
      if (drives.errors == 0 && drives.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
